/* hdl/tps_pkg.sv */
// Tone pattern sequencer package: widths, step type and pattern ROM.
package tps_pkg;

    localparam int ClkW     = 28;
    localparam int FreqW    = 11;
    localparam int DurW     = 9;
    localparam int WrapW    = 16;
    localparam int ElapsedW = 16;
    localparam int StepW    = 4;
    localparam int PatW     = 4;
    localparam int CodeW    = 8;
    localparam int AddrW    = 6;
    localparam int PatCount = 8;

    localparam logic [ClkW-1:0] ClockReset = ClkW'(125000000);

    typedef struct packed {
        logic [FreqW-1:0] freq;
        logic [DurW-1:0]  dur;
    } t_step;

    localparam logic [AddrW-1:0] PatBase [PatCount] = '{
        6'd0, 6'd6, 6'd10, 6'd14, 6'd16, 6'd18, 6'd24, 6'd28
    };
    localparam logic [StepW:0] PatLen [PatCount] = '{
        5'd6, 5'd4, 5'd4, 5'd2, 5'd2, 5'd6, 5'd4, 5'd10
    };

    function automatic t_step mk(input int f, input int d);
        t_step s;
        s.freq = FreqW'(f);
        s.dur  = DurW'(d);
        return s;
    endfunction

    function automatic t_step step_rom(input logic [AddrW-1:0] addr);
        t_step s;
        case (addr)
            6'd0:    s = mk(1000, 100);
            6'd1:    s = mk(0, 100);
            6'd2:    s = mk(1000, 100);
            6'd3:    s = mk(0, 100);
            6'd4:    s = mk(1000, 100);
            6'd6:    s = mk(800, 150);
            6'd7:    s = mk(0, 50);
            6'd8:    s = mk(1200, 150);
            6'd10:   s = mk(1200, 150);
            6'd11:   s = mk(0, 50);
            6'd12:   s = mk(800, 150);
            6'd14:   s = mk(1500, 80);
            6'd16:   s = mk(400, 500);
            6'd18:   s = mk(523, 80);
            6'd19:   s = mk(0, 30);
            6'd20:   s = mk(659, 80);
            6'd21:   s = mk(0, 30);
            6'd22:   s = mk(784, 80);
            6'd24:   s = mk(2000, 60);
            6'd25:   s = mk(0, 40);
            6'd26:   s = mk(2000, 60);
            6'd28:   s = mk(523, 80);
            6'd29:   s = mk(0, 30);
            6'd30:   s = mk(659, 80);
            6'd31:   s = mk(0, 30);
            6'd32:   s = mk(784, 80);
            6'd33:   s = mk(0, 30);
            6'd34:   s = mk(1047, 80);
            6'd35:   s = mk(0, 30);
            6'd36:   s = mk(784, 80);
            default: s = mk(0, 0);
        endcase
        return s;
    endfunction

    function automatic t_step fetch_step(input logic [PatW-1:0] pat,
                                         input logic [StepW-1:0] idx);
        t_step            s;
        logic [PatW-2:0]  p;
        s = mk(0, 0);
        p = 3'(pat - 4'd1);
        if (pat >= 4'd1 && pat <= 4'd8) begin
            if ({1'b0, idx} < PatLen[p]) begin
                s = step_rom(AddrW'(PatBase[p] + AddrW'(idx)));
            end
        end
        return s;
    endfunction

endpackage

/* hdl/tone_pattern_sequencer.sv */
// Tone pattern sequencer top level: pattern stepping, tone setup and result register.
//
//  channel   dir  handshake                        payload
//  config    in   i_cfg_valid / o_cfg_ready        i_cfg_data: clock_hz
//  items     in   s_axis_tvalid / s_axis_tready    s_axis_tuser: func, s_axis_tdata: pattern
//  results   out  m_axis_tvalid / m_axis_tready    m_axis_tdata: tone fields and step
//
// An item that changes to a sounding tone passes through the bit-serial divider (one
// quotient bit per cycle), the registered completion flag and the wrap load before its
// result is registered; any other item goes straight to the result register.
// The next item can be accepted as soon as the result is presented. A result that is not
// taken holds the next finished item, and with it the input, until the register is free.
// Reset is synchronous and restores clock_hz to 125000000 with the sequencer idle.
module tone_pattern_sequencer
    import tps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [ClkW-1:0]    i_cfg_data,      // clock_hz
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [CodeW-1:0]   s_axis_tdata,    // pattern
    input  logic               s_axis_tuser,    // func
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [39:0]        m_axis_tdata     // tone_on, period_wrap, duty_level,
                                                // playing, step_number, zero pad
);

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StDiv  = 2'd1;
    localparam logic [1:0] StDone = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [ClkW-1:0]     r_clock_hz;
    logic [PatW-1:0]     r_pat, n_pat;
    logic [StepW-1:0]    r_step, n_step;
    logic [ElapsedW-1:0] r_elapsed, n_elapsed;
    logic                r_running, n_running;
    logic                r_tone_en, n_tone_en;
    logic [WrapW-1:0]    r_wrap, n_wrap;
    logic                r_out_valid, n_out_valid;
    logic [39:0]         r_out_data, n_out_data;

    logic                w_accept;
    logic                w_div_start;
    logic [FreqW-1:0]    w_freq;
    logic                w_div_done;
    logic [WrapW-1:0]    w_quot;
    logic [ElapsedW-1:0] w_el_inc;
    logic [StepW-1:0]    w_step_inc;
    t_step               w_cur;
    t_step               w_nxt;
    t_step               w_first;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == StIdle);
    assign o_cfg_ready   = (r_state == StIdle);

    assign w_el_inc   = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;
    assign w_step_inc = r_step + 1'b1;
    assign w_cur      = fetch_step(r_pat, r_step);
    assign w_nxt      = fetch_step(r_pat, w_step_inc);
    assign w_first    = fetch_step(s_axis_tdata[PatW-1:0], '0);

    always_comb begin
        n_state     = r_state;
        n_pat       = r_pat;
        n_step      = r_step;
        n_elapsed   = r_elapsed;
        n_running   = r_running;
        n_tone_en   = r_tone_en;
        n_wrap      = r_wrap;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        w_div_start = 1'b0;
        w_freq      = '0;
        unique case (r_state)
            StIdle: begin
                if (w_accept) begin
                    n_state = StDone;
                    if (s_axis_tuser) begin
                        if (s_axis_tdata >= 8'd1 && s_axis_tdata <= 8'd8) begin
                            n_pat       = s_axis_tdata[PatW-1:0];
                            n_step      = '0;
                            n_elapsed   = '0;
                            n_running   = 1'b1;
                            w_freq      = w_first.freq;
                            w_div_start = (w_freq != '0);
                            if (w_freq == '0) begin
                                n_tone_en = 1'b0;
                                n_wrap    = '0;
                            end
                        end
                    end else if (r_running) begin
                        n_elapsed = w_el_inc;
                        if (w_el_inc >= ElapsedW'(w_cur.dur)) begin
                            n_step = w_step_inc;
                            if (w_nxt.freq == '0 && w_nxt.dur == '0) begin
                                n_tone_en = 1'b0;
                                n_wrap    = '0;
                                n_running = 1'b0;
                            end else begin
                                n_elapsed   = '0;
                                w_freq      = w_nxt.freq;
                                w_div_start = (w_freq != '0);
                                if (w_freq == '0) begin
                                    n_tone_en = 1'b0;
                                    n_wrap    = '0;
                                end
                            end
                        end
                    end
                    if (w_div_start) begin
                        n_state = StDiv;
                    end
                end
            end
            StDiv: begin
                if (w_div_done) begin
                    n_tone_en = 1'b1;
                    n_wrap    = w_quot;
                    n_state   = StDone;
                end
            end
            StDone: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {3'b000, r_step, r_running, r_wrap[WrapW-1:1],
                                   r_wrap, r_tone_en};
                    n_state     = StIdle;
                end
            end
            default: begin
                n_state = StIdle;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= StIdle;
            r_clock_hz  <= ClockReset;
            r_pat       <= '0;
            r_step      <= '0;
            r_elapsed   <= '0;
            r_running   <= 1'b0;
            r_tone_en   <= 1'b0;
            r_wrap      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pat       <= n_pat;
            r_step      <= n_step;
            r_elapsed   <= n_elapsed;
            r_running   <= n_running;
            r_tone_en   <= n_tone_en;
            r_wrap      <= n_wrap;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_clock_hz <= i_cfg_data;
            end
        end
        r_out_data <= n_out_data;
    end

    tps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_clock_hz),
        .i_divisor  (w_freq),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

/* hdl/tps_div.sv */
// Tone sequencer serial divider: clock rate over frequency, saturated wrap.
module tps_div
    import tps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [ClkW-1:0]    i_dividend,
    input  logic [FreqW-1:0]   i_divisor,
    output logic               o_done,
    output logic [WrapW-1:0]   o_quot
);

    localparam int CntW = $clog2(ClkW);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CntW-1:0]   r_cnt, n_cnt;
    logic [FreqW-1:0]  r_rem, n_rem;
    logic [ClkW-1:0]   r_quo, n_quo;
    logic [FreqW-1:0]  r_dvs, n_dvs;
    logic [FreqW:0]    w_part;
    logic [FreqW:0]    w_trial;

    assign w_part  = {r_rem, r_quo[ClkW-1]};
    assign w_trial = w_part - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CntW'(ClkW - 1);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (!w_trial[FreqW]) begin
                n_rem = w_trial[FreqW-1:0];
                n_quo = {r_quo[ClkW-2:0], 1'b1};
            end else begin
                n_rem = w_part[FreqW-1:0];
                n_quo = {r_quo[ClkW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = (r_quo[ClkW-1:WrapW] != '0) ? '1 : r_quo[WrapW-1:0];

endmodule

/* sim/tb_tone_pattern_sequencer.sv */
// Testbench for the tone pattern sequencer: random stimulus checked against a tone predictor.
`timescale 1ns / 100ps

module tb_tone_pattern_sequencer;
    import tps_pkg::*;

    localparam bit FuncTick  = 1'b0;
    localparam bit FuncStart = 1'b1;
    localparam logic [ClkW-1:0] ClockMax = {ClkW{1'b1}};

    typedef struct packed {
        logic [3:0]  step_number;
        logic        playing;
        logic [14:0] duty_level;
        logic [15:0] period_wrap;
        logic        tone_on;
    } tone_result_t;

    class tone_ledger;
        int unsigned rom_freq [38] = '{
            1000, 0, 1000, 0, 1000, 0,
            800, 0, 1200, 0,
            1200, 0, 800, 0,
            1500, 0,
            400, 0,
            523, 0, 659, 0, 784, 0,
            2000, 0, 2000, 0,
            523, 0, 659, 0, 784, 0, 1047, 0, 784, 0
        };
        int unsigned rom_dur [38] = '{
            100, 100, 100, 100, 100, 0,
            150, 50, 150, 0,
            150, 50, 150, 0,
            80, 0,
            500, 0,
            80, 30, 80, 30, 80, 0,
            60, 40, 60, 0,
            80, 30, 80, 30, 80, 30, 80, 30, 80, 0
        };
        int unsigned pat_first [8] = '{0, 6, 10, 14, 16, 18, 24, 28};
        int unsigned pat_steps [8] = '{6, 4, 4, 2, 2, 6, 4, 10};

        logic [ClkW-1:0] clock_hz;
        logic [3:0]      pattern;
        logic [3:0]      step;
        logic [15:0]     elapsed;
        bit              running;
        bit              tone_en;
        logic [15:0]     wrap;
        tone_result_t    expected_tones [$];
        int              mismatches;

        function new();
            clock_hz   = ClockReset;
            pattern    = '0;
            step       = '0;
            elapsed    = '0;
            running    = 1'b0;
            tone_en    = 1'b0;
            wrap       = '0;
            mismatches = 0;
        endfunction

        function void lookup(input logic [3:0] p, input logic [3:0] idx,
                             output int unsigned freq, output int unsigned dur);
            freq = 0;
            dur  = 0;
            if (p >= 1 && p <= 8 && idx < pat_steps[p-1]) begin
                freq = rom_freq[pat_first[p-1] + idx];
                dur  = rom_dur[pat_first[p-1] + idx];
            end
        endfunction

        function int unsigned run_length(input logic [3:0] p);
            int unsigned sum;
            sum = 0;
            for (int i = 0; i < pat_steps[p-1]; i++) sum += rom_dur[pat_first[p-1] + i];
            return sum;
        endfunction

        function void set_tone(input int unsigned freq);
            int unsigned q;
            if (freq == 0) begin
                tone_en = 1'b0;
                wrap    = '0;
            end else begin
                q       = clock_hz / freq;
                wrap    = (q > 65535) ? 16'hFFFF : q[15:0];
                tone_en = 1'b1;
            end
        endfunction

        function void log_item(input bit func, input logic [CodeW-1:0] code);
            int unsigned  freq, dur;
            tone_result_t r;
            if (func == FuncStart) begin
                if (code >= 1 && code <= 8) begin
                    pattern = code[3:0];
                    step    = '0;
                    elapsed = '0;
                    running = 1'b1;
                    lookup(pattern, step, freq, dur);
                    set_tone(freq);
                end
            end else if (running) begin
                if (elapsed != 16'hFFFF) elapsed++;
                lookup(pattern, step, freq, dur);
                if (elapsed >= dur) begin
                    step = step + 4'd1;
                    lookup(pattern, step, freq, dur);
                    if (freq == 0 && dur == 0) begin
                        set_tone(0);
                        running = 1'b0;
                    end else begin
                        set_tone(freq);
                        elapsed = '0;
                    end
                end
            end
            r.tone_on     = tone_en;
            r.period_wrap = tone_en ? wrap : 16'h0;
            r.duty_level  = tone_en ? wrap[15:1] : 15'h0;
            r.playing     = running;
            r.step_number = step;
            expected_tones.push_back(r);
        endfunction

        function void check_result(input logic [39:0] data);
            tone_result_t got, want;
            got = data[36:0];
            if (expected_tones.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: on=%0d wrap=%0d duty=%0d play=%0d step=%0d",
                             got.tone_on, got.period_wrap, got.duty_level, got.playing,
                             got.step_number);
                return;
            end
            want = expected_tones.pop_front();
            if (got.tone_on !== want.tone_on || got.period_wrap !== want.period_wrap ||
                got.duty_level !== want.duty_level || got.playing !== want.playing ||
                got.step_number !== want.step_number || data[39:37] !== 3'b000) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("mismatch: exp on=%0d wrap=%0d duty=%0d play=%0d step=%0d",
                           want.tone_on, want.period_wrap, want.duty_level, want.playing,
                           want.step_number);
                    $display(" | act on=%0d wrap=%0d duty=%0d play=%0d step=%0d pad=%b",
                             got.tone_on, got.period_wrap, got.duty_level, got.playing,
                             got.step_number, data[39:37]);
                end
            end
        endfunction

        function int pending();
            return expected_tones.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n        = 1'b0;
    logic               i_cfg_valid    = 1'b0;
    logic               o_cfg_ready;
    logic [ClkW-1:0]    i_cfg_data     = '0;
    logic               s_axis_tvalid  = 1'b0;
    logic               s_axis_tready;
    logic [CodeW-1:0]   s_axis_tdata   = '0;    // pattern
    logic               s_axis_tuser   = 1'b0;  // func
    logic               m_axis_tvalid;
    logic               m_axis_tready  = 1'b0;
    logic [39:0]        m_axis_tdata;           // tone_on, period_wrap, duty_level,
                                                // playing, step_number, zero pad

    tone_ledger ledger;
    bit         calm = 1'b0;
    int         counted = 0;
    int         budget = 0;
    bit         finished_run [8];

    tone_pattern_sequencer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("tb_tone_pattern_sequencer: done, errors");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) ledger.clock_hz = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready) ledger.log_item(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) ledger.check_result(m_axis_tdata);
        end
    end

    // Stall the result side in bursts, with the odd long open stretch; when calm, always ready.
    initial begin
        int n;
        int mode;
        @(posedge i_clk);
        forever begin
            if (calm) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                n    = $urandom_range(1, 16);
                mode = $urandom_range(0, 3);
                if (mode == 0) begin
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                    if (mode == 1) n = $urandom_range(20, 80);
                end
                repeat (n) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input bit func, input logic [CodeW-1:0] code);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= code;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (ledger.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_clock(input logic [ClkW-1:0] hz);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= hz;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [CodeW-1:0] bad_code();
        if ($urandom_range(0, 3) == 0) return 8'd0;
        return 8'($urandom_range(9, 255));
    endfunction

    function automatic logic [ClkW-1:0] clock_for_phase(input int phase);
        case (phase)
            0:       return '0;
            1:       return 28'd1;
            2:       return ClockMax;
            3:       return 28'd200000000;
            4:       return ClockReset;
            default: return (phase % 2) ? 28'($urandom_range(1, 131070000))
                                         : 28'($urandom);
        endcase
    endfunction

    // Start a pattern and tick it through, fully or partly; now and then send noise.
    task automatic play_sequence();
        int          kind;
        int          n;
        int          offset;
        logic [3:0]  p;
        kind = $urandom_range(0, 9);
        if (kind == 9) begin
            repeat ($urandom_range(1, 10)) send_item(1'($urandom_range(0, 1)),
                                                     8'($urandom_range(0, 255)));
            return;
        end
        p = 4'($urandom_range(1, 8));
        if ($urandom_range(0, 1) == 1) begin
            offset = $urandom_range(0, 7);
            for (int i = 0; i < 8; i++) begin
                if (!finished_run[(offset + i) % 8]) begin
                    p = 4'((offset + i) % 8 + 1);
                    break;
                end
            end
        end
        send_item(FuncStart, {4'd0, p});
        counted++;
        n = (kind < 6) ? ledger.run_length(p) + $urandom_range(0, 3)
                       : $urandom_range(0, ledger.run_length(p));
        for (int i = 0; i < n; i++) begin
            if (counted >= budget) return;
            if ($urandom_range(0, 49) == 0) send_item(FuncStart, bad_code());
            send_item(FuncTick, 8'($urandom_range(0, 255)));
            counted++;
        end
        if (kind < 6) finished_run[p-1] = 1'b1;
    endtask

    initial begin
        int phase;
        int seq;
        ledger = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Idle ticks, rejected codes, every pattern started over the previous one.
        send_item(FuncTick, 8'hFF);
        send_item(FuncTick, 8'h00);
        send_item(FuncStart, 8'd0);
        send_item(FuncStart, 8'd9);
        send_item(FuncStart, 8'hFF);
        for (int c = 1; c <= 8; c++) send_item(FuncStart, 8'(c));
        send_item(FuncTick, 8'hAA);
        send_item(FuncStart, 8'd128);
        send_item(FuncTick, 8'h55);
        send_item(FuncStart, 8'd6);
        send_item(FuncTick, 8'h0F);

        // Play pattern 4, a two-step pattern, through its end marker, then tick while idle.
        send_item(FuncStart, 8'd4);
        repeat (ledger.run_length(4'd4) + 3) send_item(FuncTick, 8'h00);
        drain();

        phase  = 0;
        seq    = 0;
        budget = 260;
        while (counted < budget) begin
            if (seq % 8 == 0) begin
                drain();
                write_clock(clock_for_phase(phase));
                phase++;
            end
            play_sequence();
            seq++;
        end

        drain();
        write_clock(ClockReset);
        calm   = 1'b1;
        budget = 300;
        repeat (3) play_sequence();

        drain();
        repeat (40) @(posedge i_clk);
        if (ledger.pending() != 0)
            $display("%0d results never arrived", ledger.pending());
        if (ledger.mismatches == 0 && ledger.pending() == 0) begin
            $display("tb_tone_pattern_sequencer: done, clean");
        end else begin
            $display("tb_tone_pattern_sequencer: done, errors");
        end
        $finish;
    end

endmodule
